[design/qe_pkg.sv]
// shared types, widths and constants for the quaternion to zyx euler core
// no dependencies
package qe_pkg;

    localparam int IN_W     = 16;
    localparam int PROD_W   = 32;
    localparam int OP_W     = 34;
    localparam int S_W      = 30;
    localparam int MAG_W    = 29;
    localparam int THR_W    = 29;
    localparam int RAD_W    = 57;
    localparam int ROOT_W   = 29;
    localparam int SQ_W     = 58;
    localparam int SQRT_STEPS = 29;
    localparam int CORD_XW  = 37;
    localparam int CORD_ZW  = 29;
    localparam int ANG_W    = 16;
    localparam int PITCH_W  = 15;
    localparam int ATAN_LEN = 24;

    localparam logic [THR_W-1:0] THR_RESET = 29'd268435188;
    localparam logic signed [OP_W-1:0] ONE_Q28 = 34'sd268435456;
    localparam logic signed [S_W-1:0] ONE_S = 30'sd268435456;
    localparam logic [RAD_W-1:0] RAD_ONE = 57'h100000000000000;
    localparam logic signed [CORD_ZW-1:0] PI_Q24 = 29'sd52707179;
    localparam logic signed [CORD_ZW-1:0] ROUND_Q24 = 29'sd1024;
    localparam logic signed [CORD_ZW-1:0] PI_Q13 = 29'sd25736;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q13 = 16'sd12868;

    typedef struct packed {
        logic signed [S_W-1:0]  s;
        logic                   lock;
        logic signed [OP_W-1:0] roll_y;
        logic signed [OP_W-1:0] roll_x;
        logic signed [OP_W-1:0] yaw_y;
        logic signed [OP_W-1:0] yaw_x;
    } side_t;

    typedef struct packed {
        logic lock;
        logic s_neg;
    } tail_t;

    function automatic logic signed [CORD_ZW-1:0] atan_q24(input int i);
        logic signed [CORD_ZW-1:0] a;
        case (i)
            0:  a = 29'sd13176795;
            1:  a = 29'sd7778716;
            2:  a = 29'sd4110060;
            3:  a = 29'sd2086331;
            4:  a = 29'sd1047214;
            5:  a = 29'sd524117;
            6:  a = 29'sd262123;
            7:  a = 29'sd131069;
            8:  a = 29'sd65536;
            9:  a = 29'sd32768;
            10: a = 29'sd16384;
            11: a = 29'sd8192;
            12: a = 29'sd4096;
            13: a = 29'sd2048;
            14: a = 29'sd1024;
            15: a = 29'sd512;
            16: a = 29'sd256;
            17: a = 29'sd128;
            18: a = 29'sd64;
            19: a = 29'sd32;
            20: a = 29'sd16;
            21: a = 29'sd8;
            22: a = 29'sd4;
            23: a = 29'sd2;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

[design/qe_sqrt.sv]
// pipelined floor integer square root, one result bit per stage
// depends on qe_pkg
module qe_sqrt (
    input  logic                       clk,
    input  logic [qe_pkg::RAD_W-1:0]   radicand,
    output logic [qe_pkg::ROOT_W-1:0]  root
);

    localparam int STEPS = qe_pkg::SQRT_STEPS;
    localparam int SW = qe_pkg::SQ_W;

    logic [SW-1:0] v_reg [STEPS];
    logic [SW-1:0] r_reg [STEPS];

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        localparam int K = 2 * (STEPS - 1 - i);
        logic [SW-1:0] v_in;
        logic [SW-1:0] r_in;
        logic [SW-1:0] step_w;
        logic [SW-1:0] trial;

        if (i == 0)
        begin : g_first
            assign v_in = {{(SW-qe_pkg::RAD_W){1'b0}}, radicand};
            assign r_in = '0;
        end
        else
        begin : g_rest
            assign v_in = v_reg[i-1];
            assign r_in = r_reg[i-1];
        end

        assign step_w = {{(SW-1){1'b0}}, 1'b1} << K;
        assign trial  = r_in + step_w;

        always_ff @(posedge clk)
        begin
            if (v_in >= trial)
            begin
                v_reg[i] <= v_in - trial;
                r_reg[i] <= (r_in >> 1) + step_w;
            end
            else
            begin
                v_reg[i] <= v_in;
                r_reg[i] <= r_in >> 1;
            end
        end
    end

    assign root = r_reg[STEPS-1][qe_pkg::ROOT_W-1:0];

endmodule

[design/qe_cordic.sv]
// pipelined vectoring cordic atan2, result rounded to q2.13 radians
// depends on qe_pkg
module qe_cordic #(
    parameter int STAGES = 16
) (
    input  logic                             clk,
    input  logic signed [qe_pkg::OP_W-1:0]   y_in,
    input  logic signed [qe_pkg::OP_W-1:0]   x_in,
    output logic signed [qe_pkg::ANG_W-1:0]  angle
);

    localparam int XW = qe_pkg::CORD_XW;
    localparam int ZW = qe_pkg::CORD_ZW;

    logic signed [XW-1:0] x_reg [STAGES+1];
    logic signed [XW-1:0] y_reg [STAGES+1];
    logic signed [ZW-1:0] z_reg [STAGES+1];
    logic                 zero_reg [STAGES+1];

    logic signed [ZW-1:0] z_round;
    logic signed [ZW-1:0] z_q13;
    logic signed [ZW-1:0] z_clamp;

    // fold into the right half plane
    always_ff @(posedge clk)
    begin
        zero_reg[0] <= (x_in == '0) && (y_in == '0);
        if (x_in < 0)
        begin
            x_reg[0] <= -XW'(x_in);
            y_reg[0] <= -XW'(y_in);
            z_reg[0] <= (y_in >= 0) ? qe_pkg::PI_Q24 : -qe_pkg::PI_Q24;
        end
        else
        begin
            x_reg[0] <= XW'(x_in);
            y_reg[0] <= XW'(y_in);
            z_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_iter
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            zero_reg[i+1] <= zero_reg[i];
            if (y_reg[i] > 0)
            begin
                x_reg[i+1] <= x_reg[i] + ys;
                y_reg[i+1] <= y_reg[i] - xs;
                z_reg[i+1] <= z_reg[i] + qe_pkg::atan_q24(i);
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - ys;
                y_reg[i+1] <= y_reg[i] + xs;
                z_reg[i+1] <= z_reg[i] - qe_pkg::atan_q24(i);
            end
        end
    end

    assign z_round = z_reg[STAGES] + qe_pkg::ROUND_Q24;
    assign z_q13   = z_round >>> 11;

    always_comb
    begin
        if (zero_reg[STAGES])
            z_clamp = '0;
        else if (z_q13 > qe_pkg::PI_Q13)
            z_clamp = qe_pkg::PI_Q13;
        else if (z_q13 < -qe_pkg::PI_Q13)
            z_clamp = -qe_pkg::PI_Q13;
        else
            z_clamp = z_q13;
    end

    always_ff @(posedge clk)
    begin
        angle <= z_clamp[qe_pkg::ANG_W-1:0];
    end

endmodule

[design/quaternion_to_zyx_euler_core.sv]
// top level: quaternion to zyx euler angles, fully pipelined
// depends on qe_pkg, qe_sqrt, qe_cordic
//
// channel  | handshake           | payload
// request  | start / busy        | quat_w, quat_x, quat_y, quat_z
// config   | cfg_valid/cfg_ready | cfg_data (lock threshold)
// result   | done strobe         | roll_angle, pitch_rad, yaw_rad, lock_flag
//
// one request per cycle, busy is always low
// the pipeline holds 3 front stages (products, pitch sine, square), 29 square
// root stages, CORDIC_STAGES + 2 cordic stages and the output register
// rst_n clears the valid pipe and sets the threshold to its default
// results are strobed on done for one cycle and cannot be held off
module quaternion_to_zyx_euler_core #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [qe_pkg::IN_W-1:0]      quat_w,
    input  logic signed [qe_pkg::IN_W-1:0]      quat_x,
    input  logic signed [qe_pkg::IN_W-1:0]      quat_y,
    input  logic signed [qe_pkg::IN_W-1:0]      quat_z,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [qe_pkg::THR_W-1:0]            cfg_data,
    output logic                                done,
    output logic signed [qe_pkg::ANG_W-1:0]     roll_angle,
    output logic signed [qe_pkg::PITCH_W-1:0]   pitch_rad,
    output logic signed [qe_pkg::ANG_W-1:0]     yaw_rad,
    output logic                                lock_flag
);

    localparam int OP_W = qe_pkg::OP_W;
    localparam int SQ_LAT = qe_pkg::SQRT_STEPS;
    localparam int CD_LAT = CORDIC_STAGES + 2;

    logic [qe_pkg::THR_W-1:0] thr_reg;

    logic signed [qe_pkg::PROD_W-1:0] wy_reg, xz_reg, yz_reg, wx_reg, xy_reg, wz_reg;
    logic signed [qe_pkg::PROD_W-1:0] xx_reg, yy_reg, zz_reg;
    logic v1_reg, v2_reg, v3_reg;

    logic signed [OP_W-1:0]  s_raw;
    logic signed [qe_pkg::S_W-1:0] s_clamp;
    logic [qe_pkg::MAG_W-1:0] mag;
    logic lock_next;
    qe_pkg::side_t side_next;
    qe_pkg::side_t side2_reg;
    logic [qe_pkg::MAG_W-1:0] mag_reg;

    qe_pkg::side_t side3_reg;
    logic [qe_pkg::RAD_W-1:0] sq_reg;
    logic [qe_pkg::RAD_W-1:0] rem;

    qe_pkg::side_t side_dly_reg [SQ_LAT];
    logic          vs_reg [SQ_LAT];
    logic [qe_pkg::ROOT_W-1:0] root;

    qe_pkg::side_t side_c;
    logic signed [OP_W-1:0] pitch_x;
    logic signed [qe_pkg::ANG_W-1:0] roll_ang, pitch_ang, yaw_ang;

    qe_pkg::tail_t tail_reg [CD_LAT];
    logic          vc_reg [CD_LAT];
    qe_pkg::tail_t tail_o;
    logic signed [qe_pkg::ANG_W-1:0] pitch_sel;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= qe_pkg::THR_RESET;
        else if (cfg_valid)
            thr_reg <= cfg_data;
    end

    // stage 1: products
    always_ff @(posedge clk)
    begin
        wy_reg <= qe_pkg::PROD_W'(quat_w) * qe_pkg::PROD_W'(quat_y);
        xz_reg <= qe_pkg::PROD_W'(quat_x) * qe_pkg::PROD_W'(quat_z);
        yz_reg <= qe_pkg::PROD_W'(quat_y) * qe_pkg::PROD_W'(quat_z);
        wx_reg <= qe_pkg::PROD_W'(quat_w) * qe_pkg::PROD_W'(quat_x);
        xy_reg <= qe_pkg::PROD_W'(quat_x) * qe_pkg::PROD_W'(quat_y);
        wz_reg <= qe_pkg::PROD_W'(quat_w) * qe_pkg::PROD_W'(quat_z);
        xx_reg <= qe_pkg::PROD_W'(quat_x) * qe_pkg::PROD_W'(quat_x);
        yy_reg <= qe_pkg::PROD_W'(quat_y) * qe_pkg::PROD_W'(quat_y);
        zz_reg <= qe_pkg::PROD_W'(quat_z) * qe_pkg::PROD_W'(quat_z);
    end

    // stage 2: pitch sine, lock decision, atan2 operands
    always_comb
    begin
        s_raw = (OP_W'(wy_reg) - OP_W'(xz_reg)) <<< 1;
        if (s_raw > OP_W'(qe_pkg::ONE_S))
            s_clamp = qe_pkg::ONE_S;
        else if (s_raw < -OP_W'(qe_pkg::ONE_S))
            s_clamp = -qe_pkg::ONE_S;
        else
            s_clamp = s_raw[qe_pkg::S_W-1:0];
        if (s_clamp < 0)
            mag = qe_pkg::MAG_W'(-s_clamp);
        else
            mag = qe_pkg::MAG_W'(s_clamp);
        lock_next = (mag >= thr_reg);

        side_next.s      = s_clamp;
        side_next.lock   = lock_next;
        side_next.roll_y = (OP_W'(yz_reg) + OP_W'(wx_reg)) <<< 1;
        side_next.roll_x = qe_pkg::ONE_Q28 - ((OP_W'(xx_reg) + OP_W'(yy_reg)) <<< 1);
        if (lock_next)
        begin
            side_next.yaw_y = (OP_W'(wz_reg) - OP_W'(xy_reg)) <<< 1;
            side_next.yaw_x = qe_pkg::ONE_Q28 - ((OP_W'(xx_reg) + OP_W'(zz_reg)) <<< 1);
        end
        else
        begin
            side_next.yaw_y = (OP_W'(xy_reg) + OP_W'(wz_reg)) <<< 1;
            side_next.yaw_x = qe_pkg::ONE_Q28 - ((OP_W'(yy_reg) + OP_W'(zz_reg)) <<< 1);
        end
    end

    always_ff @(posedge clk)
    begin
        side2_reg <= side_next;
        mag_reg   <= mag;
    end

    // stage 3: square of the pitch sine
    always_ff @(posedge clk)
    begin
        side3_reg <= side2_reg;
        sq_reg    <= qe_pkg::RAD_W'(mag_reg) * qe_pkg::RAD_W'(mag_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign rem = qe_pkg::RAD_ONE - sq_reg;

    qe_sqrt u_sqrt (
        .clk      (clk),
        .radicand (rem),
        .root     (root)
    );

    // side data follows the square root
    always_ff @(posedge clk)
    begin
        side_dly_reg[0] <= side3_reg;
        for (int i = 1; i < SQ_LAT; i++)
            side_dly_reg[i] <= side_dly_reg[i-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SQ_LAT; i++)
                vs_reg[i] <= 1'b0;
        end
        else
        begin
            vs_reg[0] <= v3_reg;
            for (int i = 1; i < SQ_LAT; i++)
                vs_reg[i] <= vs_reg[i-1];
        end
    end

    assign side_c  = side_dly_reg[SQ_LAT-1];
    assign pitch_x = {{(OP_W-qe_pkg::ROOT_W){1'b0}}, root};

    qe_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_pitch (
        .clk   (clk),
        .y_in  (OP_W'(side_c.s)),
        .x_in  (pitch_x),
        .angle (pitch_ang)
    );

    qe_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_roll (
        .clk   (clk),
        .y_in  (side_c.roll_y),
        .x_in  (side_c.roll_x),
        .angle (roll_ang)
    );

    qe_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_yaw (
        .clk   (clk),
        .y_in  (side_c.yaw_y),
        .x_in  (side_c.yaw_x),
        .angle (yaw_ang)
    );

    always_ff @(posedge clk)
    begin
        tail_reg[0].lock  <= side_c.lock;
        tail_reg[0].s_neg <= side_c.s < 0;
        for (int i = 1; i < CD_LAT; i++)
            tail_reg[i] <= tail_reg[i-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CD_LAT; i++)
                vc_reg[i] <= 1'b0;
        end
        else
        begin
            vc_reg[0] <= vs_reg[SQ_LAT-1];
            for (int i = 1; i < CD_LAT; i++)
                vc_reg[i] <= vc_reg[i-1];
        end
    end

    assign tail_o = tail_reg[CD_LAT-1];

    always_comb
    begin
        if (tail_o.lock)
            pitch_sel = tail_o.s_neg ? -qe_pkg::HALF_PI_Q13 : qe_pkg::HALF_PI_Q13;
        else if (pitch_ang > qe_pkg::HALF_PI_Q13)
            pitch_sel = qe_pkg::HALF_PI_Q13;
        else if (pitch_ang < -qe_pkg::HALF_PI_Q13)
            pitch_sel = -qe_pkg::HALF_PI_Q13;
        else
            pitch_sel = pitch_ang;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= vc_reg[CD_LAT-1];
    end

    always_ff @(posedge clk)
    begin
        roll_angle <= tail_o.lock ? '0 : roll_ang;
        pitch_rad  <= pitch_sel[qe_pkg::PITCH_W-1:0];
        yaw_rad    <= yaw_ang;
        lock_flag  <= tail_o.lock;
    end

endmodule
